### src/postfix_stack_evaluator_defines.svh
// Assertion helpers for the postfix evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PSE_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define PSE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### src/pse_pkg.sv
`default_nettype none
package pse_pkg;
   localparam int StackDepth = 64;
   localparam int LevelWidth = $clog2(StackDepth + 1);
   localparam int PtrWidth   = $clog2(StackDepth);
   localparam int NumVars    = 52;
   localparam int VarIdxWidth = 6;

   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChStar  = 8'h2A;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChCaret = 8'h5E;
   localparam logic [7:0] ChEqual = 8'h3D;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChComma = 8'h2C;

   localparam logic [2:0] ErrNone      = 3'd0;
   localparam logic [2:0] ErrUnderflow = 3'd1;
   localparam logic [2:0] ErrType      = 3'd2;
   localparam logic [2:0] ErrUnassign  = 3'd3;
   localparam logic [2:0] ErrDivZero   = 3'd4;
   localparam logic [2:0] ErrLeftover  = 3'd5;
   localparam logic [2:0] ErrOverflow  = 3'd6;

   typedef enum logic [2:0] {
      OP_SKIP, OP_DIGIT, OP_LETTER, OP_ASSIGN, OP_ARITH, OP_DROP
   } op_kind_type;

   typedef enum logic [2:0] {
      AR_ADD, AR_SUB, AR_MUL, AR_DIV, AR_POW
   } arith_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         error_code;
   } rsp_word_type;

   // classified command passed from front to back
   typedef struct packed {
      op_kind_type             kind;
      arith_type               arith;
      logic [31:0]             literal;
      logic [VarIdxWidth-1:0]  var_idx;
      logic                    is_last;
   } cmd_type;

   function automatic logic is_letter(input logic [31:0] c);
      return (c >= 32'h41 && c <= 32'h5A) || (c >= 32'h61 && c <= 32'h7A);
   endfunction

   function automatic logic [VarIdxWidth-1:0] var_index(input logic [31:0] c);
      logic [7:0] b;
      b = c[7:0];
      if (b <= 8'h5A) return VarIdxWidth'(b - 8'h41);
      return VarIdxWidth'(b - 8'h61 + 8'd26);
   endfunction
endpackage
`default_nettype wire

### src/pse_front.sv
`default_nettype none
module pse_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pse_pkg::req_word_type req_word,
   output logic                       cmd_valid,
   input  wire logic                  cmd_stall,
   output pse_pkg::cmd_type           cmd
);
   import pse_pkg::*;

   // two-entry queue
   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   always_comb begin
      q_in = '0;
      q_in.is_last = req_word.is_last;
      q_in.literal = {24'd0, req_word.symbol};
      q_in.var_idx = var_index({24'd0, req_word.symbol});
      q_in.arith = AR_ADD;
      if (req_word.symbol == ChSpace || req_word.symbol == ChComma)
         q_in.kind = OP_SKIP;
      else if (is_letter({24'd0, req_word.symbol}))
         q_in.kind = OP_LETTER;
      else if (req_word.symbol >= 8'h30 && req_word.symbol <= 8'h39) begin
         q_in.kind = OP_DIGIT;
         q_in.literal = {24'd0, req_word.symbol - 8'h30};
      end else if (req_word.symbol == ChEqual)
         q_in.kind = OP_ASSIGN;
      else begin
         q_in.kind = OP_ARITH;
         case (req_word.symbol)
            ChPlus:  q_in.arith = AR_ADD;
            ChMinus: q_in.arith = AR_SUB;
            ChStar:  q_in.arith = AR_MUL;
            ChSlash: q_in.arith = AR_DIV;
            ChCaret: q_in.arith = AR_POW;
            default: q_in.kind = OP_DROP;
         endcase
      end
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && !cmd_stall;
   assign cmd       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) q_ff[wp_ff] <= q_in;
   end
endmodule
`default_nettype wire

### src/pse_arith.sv
`default_nettype none
module pse_arith (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire pse_pkg::arith_type op,
   input  wire logic [31:0]       lhs,
   input  wire logic [31:0]       rhs,
   output logic                   done,
   output logic [31:0]            result,
   output logic                   div_zero
);
   import pse_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_POW, S_DONE} st_type;
   st_type      st_ff;
   logic [31:0] a_ff, b_ff, r_ff, q_ff, rem_ff;
   logic [5:0]  n_ff;
   logic        neg_q_ff, dz_ff, sq_ff;
   logic [32:0] trial;
   logic [31:0] rem_sh;
   logic [63:0] prod;
   logic [31:0] mul_a, mul_b;

   assign rem_sh = {rem_ff[30:0], a_ff[31]};
   assign trial  = {1'b0, rem_sh} - {1'b0, b_ff};
   assign mul_a  = sq_ff ? b_ff : r_ff;
   assign mul_b  = b_ff;
   assign prod   = mul_a * mul_b;
   assign done     = (st_ff == S_DONE);
   assign result   = r_ff;
   assign div_zero = dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         case (st_ff)
            S_IDLE: if (start) begin
               dz_ff <= 1'b0;
               sq_ff <= 1'b0;
               case (op)
                  AR_ADD: begin r_ff <= lhs + rhs; st_ff <= S_DONE; end
                  AR_SUB: begin r_ff <= lhs - rhs; st_ff <= S_DONE; end
                  AR_MUL: begin
                     r_ff <= 32'(lhs * rhs); st_ff <= S_DONE;
                  end
                  AR_DIV: begin
                     if (rhs == 0) begin
                        dz_ff <= 1'b1; st_ff <= S_DONE;
                     end else begin
                        a_ff <= lhs[31] ? -lhs : lhs;
                        b_ff <= rhs[31] ? -rhs : rhs;
                        neg_q_ff <= lhs[31] ^ rhs[31];
                        rem_ff <= '0; q_ff <= '0; n_ff <= 6'd32;
                        st_ff <= S_DIV;
                     end
                  end
                  AR_POW: begin
                     if (rhs[31]) begin
                        st_ff <= S_DONE;
                        if (lhs == 32'd1) r_ff <= 32'd1;
                        else if (lhs == 32'hFFFF_FFFF)
                           r_ff <= rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                        else if (lhs == 0) begin r_ff <= '0; dz_ff <= 1'b1; end
                        else r_ff <= '0;
                     end else begin
                        r_ff <= 32'd1; b_ff <= lhs; a_ff <= rhs;
                        st_ff <= S_POW;
                     end
                  end
                  default: st_ff <= S_DONE;
               endcase
            end
            S_DIV: begin
               if (!trial[32]) begin
                  rem_ff <= trial[31:0]; q_ff <= {q_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh; q_ff <= {q_ff[30:0], 1'b0};
               end
               a_ff <= {a_ff[30:0], 1'b0};
               n_ff <= n_ff - 6'd1;
               if (n_ff == 6'd1) begin
                  r_ff <= neg_q_ff ? -{q_ff[30:0], !trial[32]}
                                   : {q_ff[30:0], !trial[32]};
                  st_ff <= S_DONE;
               end
            end
            S_POW: begin
               // alternate: multiply step, then square step
               if (a_ff == 0) st_ff <= S_DONE;
               else if (!sq_ff) begin
                  if (a_ff[0]) r_ff <= prod[31:0];
                  sq_ff <= 1'b1;
               end else begin
                  b_ff <= prod[31:0];
                  a_ff <= a_ff >> 1;
                  sq_ff <= 1'b0;
               end
            end
            S_DONE: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### src/pse_back.sv
`default_nettype none
module pse_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_stall,
   input  wire pse_pkg::cmd_type      cmd,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pse_pkg::rsp_word_type      rsp_word
);
   import pse_pkg::*;
   `include "postfix_stack_evaluator_defines.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_RD2, S_WAIT2, S_EVAL, S_VAR, S_MATH, S_PUSH,
      S_FIN, S_FIN_RD, S_CLR, S_LRD
   } st_type;

   st_type                 st_ff;
   cmd_type                c_ff;
   logic [LevelWidth-1:0]  lvl_ff;
   logic [2:0]             err_ff;
   logic [31:0]            var_ff [NumVars];
   logic [31:0]            var_rd_ff;
   logic [VarIdxWidth-1:0] var_addr;
   logic [31:0]            var_new;
   logic [NumVars-1:0]     vok_ff;
   logic [32:0]            mem [StackDepth];
   logic [32:0]            rd_ff;
   logic [PtrWidth-1:0]    rd_addr;
   logic [32:0]            op1_ff, op2_ff;
   logic [31:0]            push_v_ff;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_ff;
   logic                   ar_start, ar_done, ar_dz;
   logic                   ar_busy_ff;
   logic [31:0]            ar_res;
   logic [31:0]            v1;
   logic [VarIdxWidth-1:0] i1;

   assign cmd_stall = (st_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign ar_start  = (st_ff == S_MATH) && (err_ff == ErrNone) && !ar_done
                      && !ar_busy_ff;

   // vok marks a variable holding a nonzero value
   assign i1       = var_index(op1_ff[31:0]);
   assign var_addr = (st_ff == S_IDLE) ? cmd.var_idx : i1;
   assign v1 = (is_letter(op1_ff[31:0]) && vok_ff[i1]) ? var_rd_ff : 32'd0;
   assign var_new = op1_ff[32] ? v1 : op1_ff[31:0];

   pse_arith u_arith (
      .clock, .reset, .start(ar_start), .op(c_ff.arith),
      .lhs(op2_ff[31:0]), .rhs(op1_ff[32] ? v1 : op1_ff[31:0]),
      .done(ar_done), .result(ar_res), .div_zero(ar_dz)
   );

   always_comb begin
      rd_addr = PtrWidth'(lvl_ff - LevelWidth'(1));
      if (st_ff == S_RD2) rd_addr = PtrWidth'(lvl_ff - LevelWidth'(2));
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_RD1 || st_ff == S_RD2 || st_ff == S_FIN) rd_ff <= mem[rd_addr];
      if (st_ff == S_PUSH && lvl_ff < LevelWidth'(StackDepth))
         mem[lvl_ff[PtrWidth-1:0]] <= {1'b0, push_v_ff};
      if (st_ff == S_LRD && lvl_ff < LevelWidth'(StackDepth))
         mem[lvl_ff[PtrWidth-1:0]] <= vok_ff[c_ff.var_idx]
            ? {1'b0, var_rd_ff} : {1'b1, c_ff.literal};
      if (st_ff == S_IDLE && cmd_valid && cmd.kind == OP_DIGIT
          && lvl_ff < LevelWidth'(StackDepth))
         mem[lvl_ff[PtrWidth-1:0]] <= {1'b0, cmd.literal};
      var_rd_ff <= var_ff[var_addr];
      if (st_ff == S_VAR) var_ff[var_index(op2_ff[31:0])] <= var_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         lvl_ff <= '0;
         err_ff <= ErrNone;
         vok_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ar_busy_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && st_ff != S_FIN_RD) rsp_valid_ff <= 1'b0;
         if (ar_start) ar_busy_ff <= 1'b1;
         if (ar_done) ar_busy_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (cmd_valid) begin
               c_ff <= cmd;
               if (err_ff != ErrNone || cmd.kind == OP_SKIP)
                  st_ff <= cmd.is_last ? S_FIN : S_IDLE;
               else if (cmd.kind == OP_DIGIT) begin
                  if (lvl_ff >= LevelWidth'(StackDepth)) err_ff <= ErrOverflow;
                  else lvl_ff <= lvl_ff + LevelWidth'(1);
                  st_ff <= cmd.is_last ? S_FIN : S_IDLE;
               end else if (cmd.kind == OP_LETTER) begin
                  st_ff <= S_LRD;
               end else if (lvl_ff < LevelWidth'(2)) begin
                  err_ff <= ErrUnderflow;
                  st_ff <= cmd.is_last ? S_FIN : S_IDLE;
               end else st_ff <= S_RD1;
            end
            // variable value is read; push it or the tagged letter
            S_LRD: begin
               if (lvl_ff >= LevelWidth'(StackDepth)) err_ff <= ErrOverflow;
               else lvl_ff <= lvl_ff + LevelWidth'(1);
               st_ff <= c_ff.is_last ? S_FIN : S_IDLE;
            end
            S_RD1: st_ff <= S_RD2;
            S_RD2: begin op1_ff <= rd_ff; st_ff <= S_WAIT2; end
            S_WAIT2: begin
               op2_ff <= rd_ff;
               lvl_ff <= lvl_ff - LevelWidth'(2);
               st_ff <= S_EVAL;
            end
            S_EVAL: begin
               st_ff <= c_ff.is_last ? S_FIN : S_IDLE;
               if (c_ff.kind == OP_ASSIGN) begin
                  if (!op2_ff[32] || !is_letter(op2_ff[31:0])) err_ff <= ErrType;
                  else st_ff <= S_VAR;
               end else if (c_ff.kind == OP_ARITH) begin
                  if (op2_ff[32]) err_ff <= ErrType;
                  else if (op1_ff[32] && v1 == 0) err_ff <= ErrUnassign;
                  else st_ff <= S_MATH;
               end
            end
            S_VAR: begin
               vok_ff[var_index(op2_ff[31:0])] <= (var_new != 32'd0);
               st_ff <= c_ff.is_last ? S_FIN : S_IDLE;
            end
            S_MATH: if (ar_done) begin
               if (ar_dz) begin
                  err_ff <= ErrDivZero;
                  st_ff <= c_ff.is_last ? S_FIN : S_IDLE;
               end else begin
                  push_v_ff <= ar_res;
                  st_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (lvl_ff >= LevelWidth'(StackDepth)) err_ff <= ErrOverflow;
               else lvl_ff <= lvl_ff + LevelWidth'(1);
               st_ff <= c_ff.is_last ? S_FIN : S_IDLE;
            end
            S_FIN: st_ff <= S_FIN_RD;
            S_FIN_RD: if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.error_code <= err_ff;
               rsp_ff.value <= '0;
               if (err_ff == ErrNone && lvl_ff != 0) begin
                  if (lvl_ff > LevelWidth'(1)) rsp_ff.error_code <= ErrLeftover;
                  else rsp_ff.value <= rd_ff[31:0];
               end
               st_ff <= S_CLR;
            end
            S_CLR: begin
               lvl_ff <= '0; err_ff <= ErrNone; vok_ff <= '0;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   `PSE_ASSERT_IMP(a_lvl_range, clock, reset, 1'b1,
      lvl_ff <= LevelWidth'(StackDepth), "stack level beyond depth")
   `PSE_ASSERT_NEXT(a_clear, clock, reset, st_ff == S_CLR,
      lvl_ff == 0 && err_ff == ErrNone, "clear after result failed")
   `PSE_ASSERT_IMP(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff),
      $past(st_ff) == S_FIN_RD, "result not from final step")
endmodule
`default_nettype wire

### src/postfix_stack_evaluator.sv
`default_nettype none
// Postfix evaluator: one ASCII character per req word; the word flagged
// is_last yields one rsp word holding the top value and an error code, then
// the stack, variables and error clear. A front classifier feeds a two-deep
// command queue (an accepted word is registered there before the back sees it);
// the back unit runs the 64-entry stack (one read port), a 52-entry variable
// store with a registered read, and a shared arithmetic unit. A letter first
// reads the variable store; an operator reads two operands from the stack,
// checks them, then assigns or waits for the arithmetic unit and pushes the
// result. Words after an error are skipped. The final word then reads the
// top entry and sends the rsp word, which waits while rsp_stall holds.
module postfix_stack_evaluator (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pse_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pse_pkg::rsp_word_type      rsp_word
);
   import pse_pkg::*;

   cmd_type cmd;
   logic    cmd_valid, cmd_stall;

   pse_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .cmd_valid, .cmd_stall, .cmd
   );

   pse_back u_back (
      .clock, .reset, .cmd_valid, .cmd_stall, .cmd,
      .rsp_valid, .rsp_stall, .rsp_word
   );
endmodule
`default_nettype wire
